[rtl/core/frustum_cull_box_sphere_top_macros.svh]
// Assertion helpers for the frustum culling block
`ifndef FRUSTUM_CULL_BOX_SPHERE_TOP_MACROS_SVH
`define FRUSTUM_CULL_BOX_SPHERE_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset
`define FCB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset
`define FCB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/core/fcb_pkg.sv]
// ----------------------------------------------------------------------------
// fcb_pkg
// Shared types and constants of the frustum culling block.
// ----------------------------------------------------------------------------
package fcb_pkg;
  localparam int NUM_PLANES  = 6;
  localparam int PLANE_REGS  = 6;
  localparam int COORD_WIDTH = 16;
  localparam int COEF_WIDTH  = 16;
  localparam int RAD_WIDTH   = 15;
  localparam int FRAC_BITS   = 14;
  // product coefficient x coordinate, and the full plane sum
  localparam int PROD_WIDTH  = COEF_WIDTH + COORD_WIDTH;
  localparam int SUM_WIDTH   = PROD_WIDTH + 3;
  localparam int CFG_IDX_W   = 3;
  localparam int PIPE_DEPTH  = NUM_PLANES;

  localparam logic OP_BOX    = 1'b0;
  localparam logic OP_SPHERE = 1'b1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  // item travelling down the cell chain
  typedef struct packed {
    logic   valid;
    logic   op;
    coord_t lo_x, lo_y, lo_z;
    coord_t hi_x, hi_y, hi_z;
    logic [RAD_WIDTH-1:0] radius;
    logic   visible;
  } cell_item_t;
endpackage

[rtl/core/fcb_cell.sv]
// ----------------------------------------------------------------------------
// fcb_cell
// One plane test: nearest-front corner (or center) against one plane.
// ----------------------------------------------------------------------------
module fcb_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic [63:0]           plane,
  input  fcb_pkg::cell_item_t   item_in,
  output fcb_pkg::cell_item_t   item_out
);
  localparam int PW = fcb_pkg::PROD_WIDTH;
  localparam int SW = fcb_pkg::SUM_WIDTH;

  logic signed [15:0] ca, cb, cc, cd;
  fcb_pkg::coord_t px, py, pz;
  logic gx, gy, gz;
  logic signed [PW-1:0] mx, my, mz;
  logic signed [SW-1:0] s, lim;
  logic cull;
  fcb_pkg::cell_item_t item_r, item_nxt;

  assign ca = plane[15:0];
  assign cb = plane[31:16];
  assign cc = plane[47:32];
  assign cd = plane[63:48];

  // box: the corner with the largest value for this plane; any corner in
  // front exists exactly when this one is. Per axis that is the larger of
  // the two bounds for a positive normal and the smaller one otherwise, so a
  // minimum above its maximum is handled too. Sphere uses its center.
  always_comb begin
    gx = item_in.lo_x > item_in.hi_x;
    gy = item_in.lo_y > item_in.hi_y;
    gz = item_in.lo_z > item_in.hi_z;
    if (item_in.op == fcb_pkg::OP_SPHERE) begin
      px = item_in.lo_x; py = item_in.lo_y; pz = item_in.lo_z;
    end else begin
      px = (ca[15] ^ gx) ? item_in.lo_x : item_in.hi_x;
      py = (cb[15] ^ gy) ? item_in.lo_y : item_in.hi_y;
      pz = (cc[15] ^ gz) ? item_in.lo_z : item_in.hi_z;
    end
    mx = PW'(ca) * PW'(px);
    my = PW'(cb) * PW'(py);
    mz = PW'(cc) * PW'(pz);
    s  = SW'(mx) + SW'(my) + SW'(mz) + (SW'(cd) <<< fcb_pkg::FRAC_BITS);
    lim = (item_in.op == fcb_pkg::OP_SPHERE)
        ? -(SW'({1'b0, item_in.radius}) <<< fcb_pkg::FRAC_BITS) : '0;
    cull = s < lim;
    item_nxt = item_in;
    item_nxt.visible = item_in.visible & ~cull;
  end

  // cell register, holds while the chain is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.valid <= 1'b0;
    end else if (adv) begin
      item_r <= item_nxt;
    end
  end

  assign item_out = item_r;
endmodule

[rtl/core/frustum_cull_box_sphere_top.sv]
// ----------------------------------------------------------------------------
// frustum_cull_box_sphere_top
// Box and sphere culling against six configured frustum planes.
// ----------------------------------------------------------------------------
// Usage: in_* carries one query item (box corners or sphere), out_* returns
// one visible flag per item in order. cfg_* writes the six 64-bit plane
// registers (index 0..5 near, far, left, right, top, bottom); write only when
// idle. Items pass a chain of six cells, one plane per cell, each cell one
// register stage, and the chain takes one item per cycle unless stalled.
// When the receiver stalls the whole chain holds; in_tready follows
// out_tready or an empty last cell, so the chain moves whenever the output
// slot is free. Reset clears all planes (every item then visible) and
// empties the chain.
// ----------------------------------------------------------------------------
`include "frustum_cull_box_sphere_top_macros.svh"
module frustum_cull_box_sphere_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: min_x,min_y,min_z,max_x,max_y,max_z,center_x,center_y,center_z,
  //        sphere_radius, 1 pad bit
  input  logic [159:0] in_tdata,
  // tuser: operation
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: visible, 7 pad bits
  output logic [7:0]  out_tdata
);
  localparam int N = fcb_pkg::NUM_PLANES;

  logic [63:0] plane_r [N];
  fcb_pkg::cell_item_t chain [N+1];
  fcb_pkg::cell_item_t head;
  logic adv;

  // plane registers; planes without a register stay zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) plane_r[i] <= '0;
    end else if (cfg_we) begin
      for (int i = 0; i < N; i++)
        if (i < fcb_pkg::PLANE_REGS && cfg_index == fcb_pkg::CFG_IDX_W'(i))
          plane_r[i] <= cfg_wdata;
    end
  end

  // input item into the chain head; sphere center rides in the lo slots
  always_comb begin
    head.valid  = in_tvalid;
    head.op     = in_tuser;
    head.hi_x   = in_tdata[63:48];
    head.hi_y   = in_tdata[79:64];
    head.hi_z   = in_tdata[95:80];
    head.radius = in_tdata[158:144];
    head.visible = 1'b1;
    if (in_tuser == fcb_pkg::OP_SPHERE) begin
      head.lo_x = in_tdata[111:96];
      head.lo_y = in_tdata[127:112];
      head.lo_z = in_tdata[143:128];
    end else begin
      head.lo_x = in_tdata[15:0];
      head.lo_y = in_tdata[31:16];
      head.lo_z = in_tdata[47:32];
    end
  end

  assign chain[0] = head;
  assign adv = out_tready | ~chain[N].valid;
  assign in_tready = adv;

  for (genvar g = 0; g < N; g++) begin : g_cell
    fcb_cell u_cell (
      .clk(clk), .rst_n(rst_n), .adv(adv), .plane(plane_r[g]),
      .item_in(chain[g]), .item_out(chain[g+1])
    );
  end

  assign out_tvalid = chain[N].valid;
  assign out_tdata  = {7'd0, chain[N].visible};

  `FCB_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `FCB_ASSERT_IMP(a_rdy, clk, rst_n, !out_tvalid, in_tready)
  `FCB_ASSERT_NXT(a_flow, clk, rst_n, in_tvalid && in_tready, chain[1].valid)
endmodule

[test/frustum_cull_box_sphere_top_tb.sv]
// ----------------------------------------------------------------------------
// frustum_cull_box_sphere_top_tb
// Streams box and sphere queries through the culling block and checks each
// visible flag against a local predictor built on the plane registers.
// ----------------------------------------------------------------------------
module frustum_cull_box_sphere_top_tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RAND_ITEMS     = 1100;
  localparam int DRAIN_CYCLES   = 20;

  typedef struct {
    logic        op;
    fcb_pkg::coord_t lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
    fcb_pkg::coord_t cx, cy, cz;
    logic [14:0] radius;
  } query_t;

  typedef enum logic [2:0] {
    PL_NEAR = 3'd0, PL_FAR = 3'd1, PL_LEFT = 3'd2,
    PL_RIGHT = 3'd3, PL_TOP = 3'd4, PL_BOTTOM = 3'd5, PL_SPARE = 3'd6
  } plane_idx_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [159:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;

  int err_count = 0;
  int idle_cycles = 0;
  bit hold_rx = 0;
  bit no_gaps = 0;
  string chk_msg;

  always #2 clk = ~clk;

  frustum_cull_box_sphere_top u_top (.*);

  task automatic report(string msg);
    $display("mismatch: %s", msg);
    err_count++;
  endtask

  // Flag predictor and queue of expected flags
  class cull_scoreboard;
    logic [63:0] planes[fcb_pkg::PLANE_REGS];
    bit          flags_q[$];

    function new();
      foreach (planes[i]) planes[i] = '0;
    endfunction

    function void write_plane(logic [2:0] idx, logic [63:0] v);
      if (idx < fcb_pkg::PLANE_REGS) planes[idx] = v;
    endfunction

    function longint plane_value(logic [63:0] p, longint x, longint y, longint z);
      longint a, b, c, d;
      a = longint'($signed(p[15:0]));
      b = longint'($signed(p[31:16]));
      c = longint'($signed(p[47:32]));
      d = longint'($signed(p[63:48]));
      return a * x + b * y + c * z + d * 16384;
    endfunction

    function bit predict_visible(query_t q);
      bit front;
      longint lim;
      if (q.op == fcb_pkg::OP_BOX) begin
        for (int i = 0; i < fcb_pkg::PLANE_REGS; i++) begin
          front = 0;
          for (int k = 0; k < 8; k++)
            if (plane_value(planes[i], k[0] ? q.hi_x : q.lo_x, k[1] ? q.hi_y : q.lo_y,
                            k[2] ? q.hi_z : q.lo_z) >= 0) front = 1;
          if (!front) return 0;
        end
        return 1;
      end
      lim = -(longint'(q.radius) * 16384);
      for (int i = 0; i < fcb_pkg::PLANE_REGS; i++)
        if (plane_value(planes[i], q.cx, q.cy, q.cz) < lim) return 0;
      return 1;
    endfunction

    function void note_item(query_t q);
      flags_q.push_back(predict_visible(q));
    endfunction

    // empty string on a match, otherwise the mismatch text
    function string check_flag(logic [7:0] d);
      bit e;
      if (flags_q.size() == 0) return $sformatf("unexpected result %h", d);
      e = flags_q.pop_front();
      if (d[0] !== e) return $sformatf("visible %b, predicted %b", d[0], e);
      return "";
    endfunction
  endclass

  cull_scoreboard sb = new();

  // Result sink with random stalls and scripted hold-off
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      chk_msg = sb.check_flag(out_tdata);
      if (chk_msg != "") report(chk_msg);
    end
    if (hold_rx) out_tready <= 1'b0;
    else out_tready <= no_gaps ? 1'b1 : ($urandom_range(99) >= 13);
  end

  // Watchdog on accepted items
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_plane(plane_idx_e idx, logic [63:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sb.write_plane(idx, v);
  endtask

  // valid stays high after an accept; a drain or a gap in the next call drops it
  task automatic send_query(query_t q);
    while (!no_gaps && $urandom_range(99) < 13) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= q.op;
    in_tdata  <= {1'b0, q.radius, q.cz, q.cy, q.cx, q.hi_z, q.hi_y, q.hi_x,
                  q.lo_z, q.lo_y, q.lo_x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(q);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.flags_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic fcb_pkg::coord_t rand_coord(int mode);
    case (mode)
      0: return fcb_pkg::coord_t'($urandom);
      1: return fcb_pkg::coord_t'($urandom_range(800)) - 16'sd400;
      default: return ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  function automatic query_t rand_query();
    query_t q;
    int m;
    m = ($urandom_range(9) < 6) ? 1 : ($urandom_range(9) < 8 ? 0 : 2);
    q.op = 1'($urandom_range(1));
    q.lo_x = rand_coord(m); q.lo_y = rand_coord(m); q.lo_z = rand_coord(m);
    q.hi_x = rand_coord(m); q.hi_y = rand_coord(m); q.hi_z = rand_coord(m);
    q.cx = rand_coord(m); q.cy = rand_coord(m); q.cz = rand_coord(m);
    q.radius = (m == 1) ? 15'($urandom_range(300)) : 15'($urandom);
    return q;
  endfunction

  // Axis plane: normal n (Q1.14) along one axis, offset d
  function automatic logic [63:0] axis_plane(int axis, logic signed [15:0] n,
                                             logic signed [15:0] d);
    logic [63:0] p;
    p = '0;
    p[16*axis +: 16] = n;
    p[63:48] = d;
    return p;
  endfunction

  task automatic load_frustum(int mode);
    for (int i = 0; i < fcb_pkg::PLANE_REGS; i++) begin
      case (mode)
        0: write_plane(plane_idx_e'(i), {$urandom, $urandom});
        1: write_plane(plane_idx_e'(i), axis_plane(i / 2, (i % 2) ? -16'sd16384 : 16'sd16384,
                                                    16'($urandom_range(300))));
        2: write_plane(plane_idx_e'(i), {16'h8000, 16'h8000, 16'h8000, 16'h8000});
        default: write_plane(plane_idx_e'(i), {16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
      endcase
    end
  endtask

  initial begin
    query_t q;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset all planes are zero: everything visible
    q = '{fcb_pkg::OP_BOX, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
          16'sh7fff, 0, 0, 0, 15'h0};
    send_query(q);
    q = '{fcb_pkg::OP_SPHERE, 0, 0, 0, 0, 0, 0, 16'sh7fff, 16'sh8000, 16'sh7fff,
          15'h7fff};
    send_query(q);
    wait_drained();

    // Cube frustum |x|,|y|,|z| <= 100
    for (int i = 0; i < fcb_pkg::PLANE_REGS; i++)
      write_plane(plane_idx_e'(i), axis_plane(i / 2, (i % 2) ? -16'sd16384 : 16'sd16384,
                                              16'sd100));
    write_plane(PL_SPARE, {64{1'b1}});   // out-of-range index, ignored
    q = '{fcb_pkg::OP_BOX, -16'sd10, -16'sd10, -16'sd10, 16'sd10, 16'sd10, 16'sd10,
          0, 0, 0, 0};
    send_query(q);                       // inside
    q = '{fcb_pkg::OP_BOX, 16'sd200, 0, 0, 16'sd300, 16'sd5, 16'sd5, 0, 0, 0, 0};
    send_query(q);                       // outside
    q = '{fcb_pkg::OP_BOX, 16'sd300, 0, 0, 16'sd200, 16'sd5, 16'sd5, 0, 0, 0, 0};
    send_query(q);                       // min above max
    q = '{fcb_pkg::OP_BOX, -16'sd101, 0, 0, -16'sd100, 0, 0, 0, 0, 0, 0};
    send_query(q);                       // touching a plane
    q = '{fcb_pkg::OP_BOX, -16'sd200, 0, 0, -16'sd101, 0, 0, 0, 0, 0, 0};
    send_query(q);
    q = '{fcb_pkg::OP_BOX, 16'sd50, 16'sd50, 0, -16'sd150, -16'sd150, 0, 0, 0, 0, 0};
    send_query(q);                       // min above max, straddling
    q = '{fcb_pkg::OP_SPHERE, 0, 0, 0, 0, 0, 0, 16'sd150, 0, 0, 15'd50};
    send_query(q);                       // exactly at the limit
    q = '{fcb_pkg::OP_SPHERE, 0, 0, 0, 0, 0, 0, 16'sd151, 0, 0, 15'd50};
    send_query(q);
    q = '{fcb_pkg::OP_SPHERE, 0, 0, 0, 0, 0, 0, 0, 16'sh8000, 0, 15'd0};
    send_query(q);
    q = '{fcb_pkg::OP_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0, 16'sh7fff, 15'h7fff};
    send_query(q);
    wait_drained();

    // Random phases over several frusta, extremes included
    for (int ph = 0; ph < 11; ph++) begin
      load_frustum(ph == 2 ? 2 : (ph == 3 ? 3 : (ph % 2)));
      no_gaps = (ph == 5);
      for (int n = 0; n < RAND_ITEMS / 11; n++) begin
        if (ph == 7 && n == 10) begin
          fork
            begin hold_rx = 1; repeat (60) @(posedge clk); hold_rx = 0; end
          join_none
        end
        send_query(rand_query());
      end
      wait_drained();
    end

    if (err_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
